FILE: sv/assert_macros.svh
// Assertion macros for the checker module of the alarm slot manager.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define APSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("alarm slot manager check failed");

// Clocked assertion that is checked in every cycle, reset included.
`define APSM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("alarm slot manager check failed");

`endif

FILE: sv/apsm_pkg.sv
// Types and constants of the periodic alarm slot manager.
// No dependencies; used by the controller, the datapath and the top level.
package apsm_pkg;

	localparam int ID_W     = 8;
	localparam int PERIOD_W = 23;
	localparam int WORD_W   = 32;

	// Request codes carried on func.
	localparam logic [1:0] FUNC_SET   = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// Slot word layout: id in the top byte, periodic flag, then the period.
	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic                periodic;
		logic [PERIOD_W-1:0] period;
	} slot_word_t;

	// One table entry as it sits in the slot memory.
	typedef struct packed {
		slot_word_t          word;
		logic [PERIOD_W-1:0] countdown;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear;
		logic issue;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic issue_last;
	} status_t;

endpackage

FILE: sv/apsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the alarm slot table.
module apsm_ram #(
	parameter int WIDTH = 55,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/apsm_ctrl.sv
// Controller state machine of the alarm slot manager.
// Depends on apsm_pkg; drives the datapath through apsm_pkg::cmd_t.
module apsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            func,
	input  apsm_pkg::status_t     status,
	output logic                  busy,
	output apsm_pkg::cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = accept;
				cmd.clear = accept && (func == apsm_pkg::FUNC_CLEAR);
				if (accept && (func == apsm_pkg::FUNC_SET || func == apsm_pkg::FUNC_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/apsm_datapath.sv
// Datapath of the alarm slot manager: slot memory, valid bits, scan pipeline and result register.
// Depends on apsm_pkg and apsm_ram; steered by apsm_ctrl through apsm_pkg::cmd_t.
module apsm_datapath #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apsm_pkg::cmd_t                 cmd,
	output apsm_pkg::status_t              status,
	input  logic [1:0]                     func,
	input  logic [apsm_pkg::ID_W-1:0]      event_id,
	input  logic                           periodic,
	input  logic [apsm_pkg::PERIOD_W-1:0]  period_ticks,
	output logic                           strobe,
	output logic [apsm_pkg::ID_W-1:0]      fired_id,
	output logic                           is_overflow,
	output logic                           last
);

	localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Latched request.
	logic [1:0]                     func_q;
	apsm_pkg::slot_word_t           word_in_q;

	// Scan address and first pipeline stage.
	logic [IDXW-1:0]                rd_idx_q;
	logic                           rd_en_s1;
	logic [IDXW-1:0]                idx_s1;
	logic                           vld_s1;
	logic [SLOT_COUNT-1:0]          vld_q;

	// Search results of a set request.
	logic                           match_fnd_q;
	logic [IDXW-1:0]                match_idx_q;
	logic                           free_fnd_q;
	logic [IDXW-1:0]                free_idx_q;

	// A fired alarm waits here until it is known whether it is the final one.
	logic                           pend_q;
	logic [apsm_pkg::ID_W-1:0]      pend_id_q;

	// Result register.
	logic                           strobe_q;
	logic [apsm_pkg::ID_W-1:0]      fired_id_q;
	logic                           is_overflow_q;
	logic                           last_q;

	apsm_pkg::slot_t                rd_slot;
	apsm_pkg::slot_t                wr_slot;
	logic [$bits(apsm_pkg::slot_t)-1:0] rd_data;
	logic                           we;
	logic [IDXW-1:0]                waddr;

	apsm_pkg::slot_word_t           s1_word;
	logic                           s1_occ;
	logic [apsm_pkg::PERIOD_W-1:0]  cd_next;
	logic                           is_tick;
	logic                           is_set;
	logic                           tick_act;
	logic                           s1_fire;
	logic                           set_commit;
	logic [IDXW-1:0]                set_idx;
	logic                           set_ovf;

	logic                           out_en;
	logic [apsm_pkg::ID_W-1:0]      out_id;
	logic                           out_ovf;
	logic                           out_last;

	apsm_ram #(
		.WIDTH ($bits(apsm_pkg::slot_t)),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_slot),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	assign rd_slot           = apsm_pkg::slot_t'(rd_data);
	assign status.issue_last = (rd_idx_q == IDXW'(SLOT_COUNT - 1));

	assign is_tick = (func_q == apsm_pkg::FUNC_TICK);
	assign is_set  = (func_q == apsm_pkg::FUNC_SET);

	// An entry without its valid bit reads as an empty slot.
	assign s1_word  = vld_s1 ? rd_slot.word : '0;
	assign s1_occ   = (s1_word != '0);
	assign cd_next  = rd_slot.countdown - apsm_pkg::PERIOD_W'(1);
	assign tick_act = rd_en_s1 && is_tick && s1_occ;
	assign s1_fire  = tick_act && (cd_next == '0);

	assign set_commit = cmd.finish && is_set && (match_fnd_q || free_fnd_q);
	assign set_idx    = match_fnd_q ? match_idx_q : free_idx_q;
	assign set_ovf    = cmd.finish && is_set && !match_fnd_q && !free_fnd_q;

	always_comb begin
		we              = 1'b0;
		waddr           = idx_s1;
		wr_slot.word    = s1_word;
		wr_slot.countdown = s1_fire ? s1_word.period : cd_next;
		if (tick_act) begin
			we = 1'b1;
		end else if (set_commit) begin
			we                = 1'b1;
			waddr             = set_idx;
			wr_slot.word      = word_in_q;
			wr_slot.countdown = word_in_q.period;
		end
	end

	always_comb begin
		out_en   = 1'b0;
		out_id   = pend_id_q;
		out_ovf  = 1'b0;
		out_last = 1'b0;
		if (s1_fire && pend_q) begin
			out_en = 1'b1;
		end else if (cmd.finish && is_tick && pend_q) begin
			out_en   = 1'b1;
			out_last = 1'b1;
		end else if (set_ovf) begin
			out_en   = 1'b1;
			out_id   = '0;
			out_ovf  = 1'b1;
			out_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_en_s1    <= 1'b0;
			vld_s1      <= 1'b0;
			vld_q       <= '0;
			match_fnd_q <= 1'b0;
			free_fnd_q  <= 1'b0;
			pend_q      <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.issue;
			vld_s1   <= vld_q[rd_idx_q];
			strobe_q <= out_en;

			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.issue) begin
				rd_idx_q <= status.issue_last ? '0 : rd_idx_q + IDXW'(1);
			end

			if (cmd.load) begin
				match_fnd_q <= 1'b0;
				free_fnd_q  <= 1'b0;
			end else if (rd_en_s1 && is_set) begin
				if (!match_fnd_q && s1_word.id == word_in_q.id) begin
					match_fnd_q <= 1'b1;
				end
				if (!free_fnd_q && !s1_occ) begin
					free_fnd_q <= 1'b1;
				end
			end

			if (cmd.load || cmd.finish) begin
				pend_q <= 1'b0;
			end else if (s1_fire) begin
				pend_q <= 1'b1;
			end

			if (cmd.clear) begin
				vld_q <= '0;
			end else if (set_commit) begin
				vld_q[set_idx] <= 1'b1;
			end else if (s1_fire && !s1_word.periodic) begin
				vld_q[idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (cmd.load) begin
			func_q    <= func;
			word_in_q <= {event_id, periodic, period_ticks};
		end
		if (rd_en_s1 && is_set) begin
			if (!match_fnd_q && s1_word.id == word_in_q.id) begin
				match_idx_q <= idx_s1;
			end
			if (!free_fnd_q && !s1_occ) begin
				free_idx_q <= idx_s1;
			end
		end
		if (s1_fire) begin
			pend_id_q <= s1_word.id;
		end
		if (out_en) begin
			fired_id_q    <= out_id;
			is_overflow_q <= out_ovf;
			last_q        <= out_last;
		end
	end

	assign strobe      = strobe_q;
	assign fired_id    = fired_id_q;
	assign is_overflow = is_overflow_q;
	assign last        = last_q;

endmodule

FILE: sv/periodic_alarm_slot_manager_top.sv
// A set, tick or clear transaction is accepted when start is high and busy is low.
// A set or tick keeps busy high until its finish step, so no new transaction is accepted before
// then; the single read port of the slot memory is scanned one slot per cycle.
// A clear or an unused code does not raise busy. Tick results and a set overflow come from
// the result register, the overflow at the finish step. The receiver cannot stall.
// Reset clears every slot valid bit, so all slots read empty, and returns the controller to idle.
module periodic_alarm_slot_manager_top #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     func,
	input  logic [apsm_pkg::ID_W-1:0]      event_id,
	input  logic                           periodic,
	input  logic [apsm_pkg::PERIOD_W-1:0]  period_ticks,
	output logic                           strobe,
	output logic [apsm_pkg::ID_W-1:0]      fired_id,
	output logic                           is_overflow,
	output logic                           last
);

	// The controller owns the sequence of a transaction: it latches the
	// request, walks the scan address over every slot, waits in a drain state
	// for the registered memory read of the final slot, and then issues the
	// finishing step. The datapath only reacts to these commands.
	apsm_pkg::cmd_t    cmd;
	apsm_pkg::status_t status;

	apsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath keeps the slot table in a memory with one valid bit per
	// slot. A clear drops all valid bits at once, and an entry without
	// its valid bit counts as an empty slot. During a tick every occupied
	// slot is decremented and written back in the cycle after it is read. A
	// fired alarm is held back one step so that the final result of the
	// transaction can carry the last flag. During a set the scan records
	// the first slot with the same id and the first empty slot; the finish
	// step writes the new entry or reports an overflow.
	apsm_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.func         (func),
		.event_id     (event_id),
		.periodic     (periodic),
		.period_ticks (period_ticks),
		.strobe       (strobe),
		.fired_id     (fired_id),
		.is_overflow  (is_overflow),
		.last         (last)
	);

endmodule

FILE: sv/apsm_checker.sv
// Port-level checker of the alarm slot manager, bound to the top level.
// Depends on apsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apsm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [1:0]                     func,
	input logic                           strobe,
	input logic [apsm_pkg::ID_W-1:0]      fired_id,
	input logic                           is_overflow,
	input logic                           last
);

	logic accept;
	logic scan_req;

	assign accept   = start && !busy;
	assign scan_req = accept && (func == apsm_pkg::FUNC_SET || func == apsm_pkg::FUNC_TICK);

	// An overflow result stands alone and carries no id.
	`APSM_ASSERT(a_ovf_alone, clk, arst_n, strobe && is_overflow |-> last && fired_id == '0)
	// A set or tick transaction keeps the block busy in the following cycle.
	`APSM_ASSERT(a_scan_busy, clk, arst_n, scan_req |=> busy)
	// More results are still to come, so the transaction is still running.
	`APSM_ASSERT(a_more_busy, clk, arst_n, strobe && !last |-> busy)
	// A clear completes at once and produces nothing.
	`APSM_ASSERT(a_clear_quiet, clk, arst_n, accept && func == apsm_pkg::FUNC_CLEAR |=> !busy && !strobe)
	// The final result of a transaction is never directly followed by another.
	`APSM_ASSERT(a_last_gap, clk, arst_n, strobe && last |=> !strobe)

endmodule

bind periodic_alarm_slot_manager_top apsm_checker u_apsm_checker (.*);
